>>> sv/rlsc_pkg.sv
// ----------------------------------------------------------------------------
// rlsc_pkg
// Shared types, constants and the block order table of the record cipher.
// ----------------------------------------------------------------------------
package rlsc_pkg;

  localparam int unsigned MAX_RECORD_DEF = 256;
  localparam int unsigned CORE_SIZE      = 136;
  localparam int unsigned CORE_START     = 8;
  localparam int unsigned BLOCK_BYTES    = 32;
  localparam int unsigned CORE_BYTES     = 4 * BLOCK_BYTES;
  localparam int unsigned HDR_BYTES      = 6;
  localparam int unsigned CSUM_ADDR      = 6;

  localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [31:0] LCG_ADD = 32'h0000_6073;
  localparam logic [4:0]  SEL_MOD = 5'd24;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_MISMATCH = 3'd1,
    STAT_SHORT    = 3'd2,
    STAT_LONG     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RDOUT = 7'b0000010,
    ST_HDR   = 7'b0000100,
    ST_PA    = 7'b0001000,
    ST_SUMW  = 7'b0010000,
    ST_PB    = 7'b0100000,
    ST_TAIL  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
  } lcg_ctl_t;

  typedef logic [1:0] blk_t;

  localparam blk_t ORDER_TAB [96] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3,
    2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1,
    2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0, 2'd3,
    2'd3, 2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1,
    2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0,
    2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0
  };

  // sel is already reduced below 24
  function automatic blk_t order_blk(input logic [4:0] sel, input logic [1:0] b);
    logic [6:0] idx;
    idx = {sel, 2'b00} + {5'd0, b};
    return ORDER_TAB[idx];
  endfunction

endpackage

>>> sv/rlsc_ram.sv
// ----------------------------------------------------------------------------
// rlsc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rlsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/rlsc_lcg.sv
// ----------------------------------------------------------------------------
// rlsc_lcg
// Keystream generator: 32-bit LCG state, seeded and advanced on request.
// ----------------------------------------------------------------------------
module rlsc_lcg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlsc_pkg::lcg_ctl_t  ctl_i,
  output logic [31:0]         state_o
);

  logic [31:0] state_q, state_d, base;

  always_comb begin
    base    = ctl_i.load ? ctl_i.seed : state_q;
    state_d = state_q;
    if (ctl_i.load || ctl_i.step) begin
      state_d = base * rlsc_pkg::LCG_MUL + rlsc_pkg::LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

>>> sv/record_lcg_shuffle_cipher.sv
// A load is taken while idle; a read passes RDOUT and the result register.
// A final load answers too short or too long in the next cycle; otherwise
// processing runs one byte per cycle through the record RAM and the 128-byte
// scratch RAM, and the report comes with busy falling. Throughput: one request
// per cycle while loading, until processing starts; a read holds busy in RDOUT.
// Reset clears control state only; the record RAM holds garbage until loaded.
// ----------------------------------------------------------------------------
// record_lcg_shuffle_cipher
// Record buffer with LCG-XOR stream cipher, block shuffle and word checksum.
// ----------------------------------------------------------------------------
module record_lcg_shuffle_cipher #(
  parameter int unsigned MAX_RECORD = rlsc_pkg::MAX_RECORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       result_valid_o,
  output logic       kind_o,
  output logic [2:0] status_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int unsigned AW = $clog2(MAX_RECORD);
  localparam int unsigned LW = $clog2(MAX_RECORD + 1);
  localparam int unsigned CW = $clog2(rlsc_pkg::CORE_BYTES);

  rlsc_pkg::state_e st_q, st_d;
  logic [LW-1:0] cnt_q, cnt_d, pi_q, pi_d, len_q, len_d, rdpos_q, rdpos_d;
  logic          pv_q, pv_d;
  logic [31:0]   key_q, key_d;
  logic [15:0]   chk_q, chk_d, sum_q, sum_d;
  logic          ready_q, ready_d, ovf_q, ovf_d, done_q, done_d;
  logic          dir_q, mode_q, mode_d;
  logic          res_valid_q, res_valid_d;
  logic          kind_q, kind_d, rlast_q, rlast_d;
  logic [2:0]    status_q, status_d;
  logic [7:0]    byte_q, byte_d;

  logic          m_we, m_re, s_we, s_re;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [CW-1:0] s_waddr, s_raddr;
  logic [7:0]    m_wdata, m_rdata, s_wdata, s_rdata;

  rlsc_pkg::lcg_ctl_t lcg_ctl;
  logic [31:0]        ks;
  logic [7:0]         ks_byte;

  logic [LW-1:0] len_eff, len_new, tail_n, n_lim;
  logic          ovf_new, issue, phase_end;
  logic [4:0]    sel_raw, sel_m;
  logic [CW-1:0] ci, pci, ci_perm, pci_perm;
  logic [15:0]   sum_add;

  rlsc_ram #(.WIDTH(8), .DEPTH(MAX_RECORD)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  rlsc_ram #(.WIDTH(8), .DEPTH(rlsc_pkg::CORE_BYTES)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rlsc_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lcg_ctl),
    .state_o (ks)
  );

  assign sel_raw  = key_q[17:13];
  assign sel_m    = (sel_raw >= rlsc_pkg::SEL_MOD) ? sel_raw - rlsc_pkg::SEL_MOD : sel_raw;
  assign ci       = cnt_q[CW-1:0];
  assign pci      = pi_q[CW-1:0];
  assign ci_perm  = {rlsc_pkg::order_blk(sel_m, ci[CW-1:CW-2]), ci[CW-3:0]};
  assign pci_perm = {rlsc_pkg::order_blk(sel_m, pci[CW-1:CW-2]), pci[CW-3:0]};
  assign ks_byte  = pi_q[0] ? ks[31:24] : ks[23:16];

  assign len_eff = done_q ? '0 : len_q;
  assign tail_n  = (len_q > LW'(rlsc_pkg::CORE_SIZE)) ?
                   ((len_q - LW'(rlsc_pkg::CORE_SIZE)) & ~LW'(1)) : '0;

  always_comb begin
    n_lim = '0;
    case (st_q)
      rlsc_pkg::ST_HDR:  n_lim = LW'(rlsc_pkg::HDR_BYTES);
      rlsc_pkg::ST_PA:   n_lim = LW'(rlsc_pkg::CORE_BYTES);
      rlsc_pkg::ST_PB:   n_lim = LW'(rlsc_pkg::CORE_BYTES);
      rlsc_pkg::ST_TAIL: n_lim = tail_n;
      default:           n_lim = '0;
    endcase
  end

  assign issue     = cnt_q < n_lim;
  assign phase_end = !issue && !pv_q;

  // Sum of little-endian words: even bytes weigh 1, odd bytes weigh 256.
  always_comb begin
    if (st_q == rlsc_pkg::ST_PA) begin
      sum_add = pi_q[0] ? {m_rdata, 8'd0} : {8'd0, m_rdata};
    end else begin
      sum_add = pi_q[0] ? {s_rdata, 8'd0} : {8'd0, s_rdata};
    end
  end

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    pi_d        = pi_q;
    pv_d        = 1'b0;
    len_d       = len_q;
    rdpos_d     = rdpos_q;
    key_d       = key_q;
    chk_d       = chk_q;
    sum_d       = sum_q;
    ready_d     = ready_q;
    ovf_d       = ovf_q;
    done_d      = done_q;
    mode_d      = mode_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    status_d    = status_q;
    byte_d      = byte_q;
    rlast_d     = rlast_q;
    len_new     = len_eff;
    ovf_new     = done_q ? 1'b0 : ovf_q;
    m_we        = 1'b0;
    m_waddr     = '0;
    m_wdata     = '0;
    m_re        = 1'b0;
    m_raddr     = '0;
    s_we        = 1'b0;
    s_waddr     = '0;
    s_wdata     = '0;
    s_re        = 1'b0;
    s_raddr     = '0;
    lcg_ctl     = '0;

    if (issue) begin
      pv_d  = 1'b1;
      pi_d  = cnt_q;
      cnt_d = cnt_q + LW'(1);
    end

    case (st_q)
      rlsc_pkg::ST_IDLE: begin
        if (start) begin
          if (opcode_i == rlsc_pkg::OP_LOAD) begin
            if (done_q) begin
              done_d  = 1'b0;
              ready_d = 1'b0;
              ovf_d   = 1'b0;
              rdpos_d = '0;
              len_d   = '0;
            end
            if (len_eff < LW'(MAX_RECORD)) begin
              m_we    = 1'b1;
              m_waddr = len_eff[AW-1:0];
              m_wdata = data_byte_i;
              len_new = len_eff + LW'(1);
              len_d   = len_new;
            end else begin
              ovf_new = 1'b1;
              ovf_d   = 1'b1;
            end
            if (last_byte_i) begin
              done_d  = 1'b1;
              rdpos_d = '0;
              mode_d  = dir_q;
              kind_d  = rlsc_pkg::KIND_REPORT;
              byte_d  = '0;
              rlast_d = 1'b0;
              if (ovf_new) begin
                res_valid_d = 1'b1;
                status_d    = rlsc_pkg::STAT_LONG;
              end else if (len_new < LW'(rlsc_pkg::CORE_SIZE)) begin
                res_valid_d = 1'b1;
                status_d    = rlsc_pkg::STAT_SHORT;
              end else begin
                st_d  = rlsc_pkg::ST_HDR;
                cnt_d = '0;
              end
            end
          end else begin
            if (ready_q && rdpos_q < len_q) begin
              m_re    = 1'b1;
              m_raddr = rdpos_q[AW-1:0];
              st_d    = rlsc_pkg::ST_RDOUT;
            end else begin
              res_valid_d = 1'b1;
              kind_d      = rlsc_pkg::KIND_READ;
              status_d    = rlsc_pkg::STAT_EMPTY;
              byte_d      = '0;
              rlast_d     = 1'b0;
            end
          end
        end
      end

      rlsc_pkg::ST_RDOUT: begin
        res_valid_d = 1'b1;
        kind_d      = rlsc_pkg::KIND_READ;
        status_d    = rlsc_pkg::STAT_OK;
        byte_d      = m_rdata;
        rlast_d     = (rdpos_q + LW'(1)) == len_q;
        rdpos_d     = rdpos_q + LW'(1);
        st_d        = rlsc_pkg::ST_IDLE;
      end

      rlsc_pkg::ST_HDR: begin
        // key from bytes 0-3, checksum from bytes 6-7
        m_re    = issue;
        m_raddr = (cnt_q < LW'(4)) ? cnt_q[AW-1:0] : AW'(cnt_q + LW'(2));
        if (pv_q) begin
          if (pi_q < LW'(4)) begin
            key_d = {m_rdata, key_q[31:8]};
          end else begin
            chk_d = {m_rdata, chk_q[15:8]};
          end
        end
        if (phase_end) begin
          st_d  = rlsc_pkg::ST_PA;
          cnt_d = '0;
          sum_d = '0;
          if (!mode_q) begin
            lcg_ctl.load = 1'b1;
            lcg_ctl.seed = {16'd0, chk_q};
          end
        end
      end

      rlsc_pkg::ST_PA: begin
        m_re    = issue;
        m_raddr = AW'(cnt_q + LW'(rlsc_pkg::CORE_START));
        if (pv_q) begin
          s_we = 1'b1;
          if (mode_q) begin
            // encrypt: copy shuffled, sum plaintext words
            s_waddr = pci_perm;
            s_wdata = m_rdata;
            sum_d   = sum_q + sum_add;
          end else begin
            s_waddr      = pci;
            s_wdata      = m_rdata ^ ks_byte;
            lcg_ctl.step = pi_q[0];
          end
        end
        if (phase_end) begin
          cnt_d = '0;
          if (mode_q) begin
            st_d = rlsc_pkg::ST_SUMW;
          end else begin
            st_d  = rlsc_pkg::ST_PB;
            sum_d = '0;
          end
        end
      end

      rlsc_pkg::ST_SUMW: begin
        pv_d    = 1'b0;
        m_we    = 1'b1;
        m_waddr = AW'(cnt_q + LW'(rlsc_pkg::CSUM_ADDR));
        m_wdata = cnt_q[0] ? sum_q[15:8] : sum_q[7:0];
        cnt_d   = cnt_q + LW'(1);
        if (cnt_q[0]) begin
          st_d         = rlsc_pkg::ST_PB;
          cnt_d        = '0;
          lcg_ctl.load = 1'b1;
          lcg_ctl.seed = {16'd0, sum_q};
        end
      end

      rlsc_pkg::ST_PB: begin
        s_re    = issue;
        s_raddr = mode_q ? ci : ci_perm;
        if (pv_q) begin
          m_we    = 1'b1;
          m_waddr = AW'(pi_q + LW'(rlsc_pkg::CORE_START));
          if (mode_q) begin
            m_wdata      = s_rdata ^ ks_byte;
            lcg_ctl.step = pi_q[0];
          end else begin
            m_wdata = s_rdata;
            sum_d   = sum_q + sum_add;
          end
        end
        if (phase_end) begin
          cnt_d = '0;
          if (!mode_q && sum_q != chk_q) begin
            res_valid_d = 1'b1;
            kind_d      = rlsc_pkg::KIND_REPORT;
            status_d    = rlsc_pkg::STAT_MISMATCH;
            byte_d      = '0;
            rlast_d     = 1'b0;
            st_d        = rlsc_pkg::ST_IDLE;
          end else begin
            st_d         = rlsc_pkg::ST_TAIL;
            lcg_ctl.load = 1'b1;
            lcg_ctl.seed = key_q;
          end
        end
      end

      rlsc_pkg::ST_TAIL: begin
        // odd final byte falls outside tail_n and stays untouched
        m_re    = issue;
        m_raddr = AW'(cnt_q + LW'(rlsc_pkg::CORE_SIZE));
        if (pv_q) begin
          m_we         = 1'b1;
          m_waddr      = AW'(pi_q + LW'(rlsc_pkg::CORE_SIZE));
          m_wdata      = m_rdata ^ ks_byte;
          lcg_ctl.step = pi_q[0];
        end
        if (phase_end) begin
          res_valid_d = 1'b1;
          kind_d      = rlsc_pkg::KIND_REPORT;
          status_d    = rlsc_pkg::STAT_OK;
          byte_d      = '0;
          rlast_d     = 1'b0;
          ready_d     = 1'b1;
          st_d        = rlsc_pkg::ST_IDLE;
        end
      end

      default: begin
        st_d = rlsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= rlsc_pkg::ST_IDLE;
      cnt_q       <= '0;
      pi_q        <= '0;
      pv_q        <= 1'b0;
      len_q       <= '0;
      rdpos_q     <= '0;
      key_q       <= '0;
      chk_q       <= '0;
      sum_q       <= '0;
      ready_q     <= 1'b0;
      ovf_q       <= 1'b0;
      done_q      <= 1'b0;
      dir_q       <= 1'b0;
      mode_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      pi_q        <= pi_d;
      pv_q        <= pv_d;
      len_q       <= len_d;
      rdpos_q     <= rdpos_d;
      key_q       <= key_d;
      chk_q       <= chk_d;
      sum_q       <= sum_d;
      ready_q     <= ready_d;
      ovf_q       <= ovf_d;
      done_q      <= done_d;
      mode_q      <= mode_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    byte_q   <= byte_d;
    rlast_q  <= rlast_d;
  end

  assign busy           = (st_q != rlsc_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign out_byte_o     = byte_q;
  assign out_last_o     = rlast_q;

  a_fall_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == rlsc_pkg::OP_READ && !ready_q) |=>
      (result_valid_o && status_o == rlsc_pkg::STAT_EMPTY))
    else $error("read of no record not answered as empty");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != rlsc_pkg::STAT_OK) |-> (out_byte_o == 8'd0 && !out_last_o))
    else $error("error result carries data");

  a_report_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == rlsc_pkg::KIND_REPORT && status_o == rlsc_pkg::STAT_OK)
      |-> ready_q)
    else $error("ok report without a ready record");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record cipher: loads records byte by byte in
// both directions, reads them back and checks every report and read answer
// against a cycle-free model of the cipher, under varying request gaps.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    rlsc_pkg::opcode_e op;
    logic [7:0]        data;
    logic              last;
  } req_t;

  typedef struct {
    rlsc_pkg::kind_e   kind;
    rlsc_pkg::status_e status;
    logic [7:0]        data;
    logic              last;
  } answer_t;

  typedef struct {
    req_t    rq;
    logic    has_ans;
    answer_t ans;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       opcode_i;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       result_valid_o;
  logic       kind_o;
  logic [2:0] status_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  record_lcg_shuffle_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .status_o      (status_o),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o)
  );

  // cipher model state
  logic [7:0]  rec_mem [256];
  logic [7:0]  work_mem [256];
  int unsigned rec_len;
  int unsigned rd_pos;
  logic        rec_ready;
  logic        rec_ovf;
  logic        rec_done;
  logic        encrypt_mode;

  answer_t     pending_answers [$];
  logic        failed;
  int unsigned idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // keystream XOR over byte pairs of work_mem
  function automatic void xor_keystream(logic [31:0] seed, int unsigned from,
                                        int unsigned to);
    logic [31:0] s;
    logic [15:0] w;
    s = seed;
    for (int unsigned p = from; p + 1 < to && p + 1 < 256; p += 2) begin
      s = s * rlsc_pkg::LCG_MUL + rlsc_pkg::LCG_ADD;
      w = s[31:16];
      work_mem[p]     ^= w[7:0];
      work_mem[p + 1] ^= w[15:8];
    end
  endfunction

  function automatic logic [15:0] core_word_sum();
    logic [15:0] s;
    s = '0;
    for (int unsigned p = rlsc_pkg::CORE_START; p + 1 < rlsc_pkg::CORE_SIZE; p += 2)
      s = s + {work_mem[p + 1], work_mem[p]};
    return s;
  endfunction

  function automatic void shuffle_blocks(int unsigned sel, logic fwd);
    logic [7:0]  tmp [128];
    int unsigned base;
    int unsigned k;
    base = (sel % 24) * 4;
    for (int i = 0; i < 128; i++) tmp[i] = work_mem[rlsc_pkg::CORE_START + i];
    for (int unsigned b = 0; b < 4; b++) begin
      k = rlsc_pkg::ORDER_TAB[base + b];
      for (int unsigned i = 0; i < rlsc_pkg::BLOCK_BYTES; i++) begin
        if (fwd) work_mem[rlsc_pkg::CORE_START + k * 32 + i] = tmp[b * 32 + i];
        else     work_mem[rlsc_pkg::CORE_START + b * 32 + i] = tmp[k * 32 + i];
      end
    end
  endfunction

  // full cipher pass on work_mem for a record of at least core size
  function automatic rlsc_pkg::status_e cipher_record(int unsigned len, logic enc);
    logic [31:0] key;
    logic [15:0] csum;
    logic [15:0] sum;
    int unsigned sel;
    key = {work_mem[3], work_mem[2], work_mem[1], work_mem[0]};
    sel = (key >> 13) & 31;
    if (!enc) begin
      csum = {work_mem[7], work_mem[6]};
      xor_keystream({16'd0, csum}, rlsc_pkg::CORE_START, rlsc_pkg::CORE_SIZE);
      shuffle_blocks(sel, 1'b0);
      sum = core_word_sum();
      if (sum != csum) return rlsc_pkg::STAT_MISMATCH;
    end else begin
      sum = core_word_sum();
      work_mem[6] = sum[7:0];
      work_mem[7] = sum[15:8];
      shuffle_blocks(sel, 1'b1);
      xor_keystream({16'd0, sum}, rlsc_pkg::CORE_START, rlsc_pkg::CORE_SIZE);
    end
    if (len > rlsc_pkg::CORE_SIZE) xor_keystream(key, rlsc_pkg::CORE_SIZE, len);
    return rlsc_pkg::STAT_OK;
  endfunction

  // advance the model by one accepted request
  function automatic logic predict_answer(req_t r, output answer_t a);
    a = '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0};
    if (r.op == rlsc_pkg::OP_LOAD) begin
      if (rec_done) begin
        rec_done  = 1'b0;
        rec_ready = 1'b0;
        rec_ovf   = 1'b0;
        rec_len   = 0;
        rd_pos    = 0;
      end
      if (rec_len < 256) begin
        rec_mem[rec_len] = r.data;
        rec_len++;
      end else begin
        rec_ovf = 1'b1;
      end
      if (!r.last) return 1'b0;
      rec_done = 1'b1;
      rd_pos   = 0;
      a.kind   = rlsc_pkg::KIND_REPORT;
      if (rec_ovf) a.status = rlsc_pkg::STAT_LONG;
      else if (rec_len < rlsc_pkg::CORE_SIZE) a.status = rlsc_pkg::STAT_SHORT;
      else begin
        work_mem = rec_mem;
        a.status = cipher_record(rec_len, encrypt_mode);
        rec_mem  = work_mem;
        if (a.status == rlsc_pkg::STAT_OK) rec_ready = 1'b1;
      end
      return 1'b1;
    end
    if (rec_ready && rd_pos < rec_len) begin
      a.status = rlsc_pkg::STAT_OK;
      a.data   = rec_mem[rd_pos];
      a.last   = (rd_pos + 1 == rec_len);
      rd_pos++;
    end
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d byte=%02h last=%0d",
                 $time, kind_o, status_o, out_byte_o, out_last_o);
        failed <= 1'b1;
      end else begin
        e = pending_answers.pop_front();
        if (kind_o !== e.kind || status_o !== e.status || out_byte_o !== e.data ||
            out_last_o !== e.last) begin
          $display("%0t: mismatch exp kind=%0d status=%0d byte=%02h last=%0d",
                   $time, e.kind, e.status, e.data, e.last);
          $display("%0t:          got kind=%0d status=%0d byte=%02h last=%0d",
                   $time, kind_o, status_o, out_byte_o, out_last_o);
          failed <= 1'b1;
        end
      end
    end
  end

  task automatic issue(req_t r, logic typed, answer_t typed_ans);
    answer_t a;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= r.op;
    data_byte_i <= r.data;
    last_byte_i <= r.last;
    do @(posedge clk_i); while (busy);
    if (predict_answer(r, a)) pending_answers.push_back(typed ? typed_ans : a);
  endtask

  task automatic send(req_t r);
    issue(r, 1'b0, '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0});
  endtask

  // hold off until every answer is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_direction(logic enc);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enc;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    encrypt_mode = enc;
  endtask

  function automatic req_t read_req();
    req_t r;
    r.op   = rlsc_pkg::OP_READ;
    r.data = 8'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  // load one record and read it back; returns the number of requests sent
  task automatic run_record(int unsigned len, logic valid_ct, logic fill_ones,
                            int unsigned n_reads, output int unsigned n_sent);
    logic [7:0] img [256];
    req_t       r;
    n_sent = 0;
    for (int i = 0; i < 256; i++) img[i] = fill_ones ? 8'hFF : 8'($urandom);
    if (valid_ct && len >= rlsc_pkg::CORE_SIZE && len <= 256) begin
      work_mem = img;
      void'(cipher_record(len, 1'b1));
      img = work_mem;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) begin
        send(read_req());
        n_sent++;
      end
      r.op   = rlsc_pkg::OP_LOAD;
      r.data = (i < 256) ? img[i] : 8'($urandom);
      r.last = (i + 1 == len);
      send(r);
      n_sent++;
    end
    repeat (n_reads) begin
      send(read_req());
      n_sent++;
    end
  endtask

  initial begin
    row_t        rows [$];
    int unsigned sent;
    int unsigned phase_items;
    int unsigned len;
    int unsigned pick;
    int unsigned idle_set [4];
    logic [7:0]  ct [256];
    req_t        r;

    idle_set = '{0, 52, 0, 36};
    failed = 1'b0;
    start = 1'b0; opcode_i = 1'b0; data_byte_i = '0; last_byte_i = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = 1'b0;
    foreach (rec_mem[i]) rec_mem[i] = '0;
    rec_len = 0; rd_pos = 0; rec_ready = 0; rec_ovf = 0; rec_done = 0;
    encrypt_mode = 1'b0;
    idle_pct = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, short records, new record after completion
    rows.push_back('{'{rlsc_pkg::OP_READ, 8'h00, 1'b0}, 1,
                     '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_READ, 8'hFF, 1'b1}, 1,
                     '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_LOAD, 8'h00, 1'b0}, 0,
                     '{rlsc_pkg::KIND_REPORT, rlsc_pkg::STAT_OK, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_LOAD, 8'hFF, 1'b1}, 1,
                     '{rlsc_pkg::KIND_REPORT, rlsc_pkg::STAT_SHORT, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_READ, 8'hA5, 1'b0}, 1,
                     '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_LOAD, 8'h5A, 1'b1}, 1,
                     '{rlsc_pkg::KIND_REPORT, rlsc_pkg::STAT_SHORT, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_LOAD, 8'hFF, 1'b1}, 1,
                     '{rlsc_pkg::KIND_REPORT, rlsc_pkg::STAT_SHORT, 8'd0, 1'b0}});
    rows.push_back('{'{rlsc_pkg::OP_READ, 8'h00, 1'b1}, 1,
                     '{rlsc_pkg::KIND_READ, rlsc_pkg::STAT_EMPTY, 8'd0, 1'b0}});
    foreach (rows[i]) issue(rows[i].rq, rows[i].has_ans, rows[i].ans);

    // encrypt an all-ones record with an odd tail, then decrypt it back
    set_direction(1'b1);
    run_record(137, 1'b0, 1'b1, 138, sent);
    drain();
    ct = rec_mem;
    set_direction(1'b0);
    for (int unsigned i = 0; i < 137; i++) begin
      r = '{rlsc_pkg::OP_LOAD, ct[i], i == 136};
      send(r);
    end
    repeat (138) send(read_req());
    run_record(256, 1'b1, 1'b0, 2, sent);
    run_record(136, 1'b0, 1'b0, 2, sent);
    run_record(258, 1'b0, 1'b0, 2, sent);

    // random phases over both directions and all gap settings
    for (int ph = 0; ph < 4; ph++) begin
      set_direction(ph[0]);
      idle_pct = idle_set[ph];
      phase_items = 0;
      while (phase_items < 100) begin
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(136, 150);
        else if (pick < 75) len = $urandom_range(1, 135);
        else if (pick < 85) len = $urandom_range(151, 255);
        else if (pick < 92) len = 256;
        else                len = $urandom_range(257, 260);
        pick = $urandom_range(99);
        run_record(len, !encrypt_mode && $urandom_range(99) < 80, 1'b0,
                   (pick < 30) ? len + $urandom_range(0, 2) : $urandom_range(0, 3),
                   sent);
        phase_items += sent;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (!failed && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rlsc_pkg.sv
sv/rlsc_ram.sv
sv/rlsc_lcg.sv
sv/record_lcg_shuffle_cipher.sv
tb/tb_top.sv
